// File: design/wsce_pkg.sv
// Shared types and command codes of the world-state condition and effect engine.
package wsce_pkg;

    localparam logic [2:0] CMD_CHECK  = 3'd0;
    localparam logic [2:0] CMD_EFFECT = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] OP_LT      = 3'd0;
    localparam logic [2:0] OP_LE      = 3'd1;
    localparam logic [2:0] OP_EQ      = 3'd2;
    localparam logic [2:0] OP_NE      = 3'd3;
    localparam logic [2:0] OP_GE      = 3'd4;
    localparam logic [2:0] OP_GT      = 3'd5;
    localparam logic [2:0] OP_NONZERO = 3'd6;

    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_SUB     = 3'd2;

    localparam logic [1:0] REG_ENTRIES_IN_USE = 2'd0;
    localparam logic [6:0] ENTRIES_RESET      = 7'd64;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  op_code;
        logic [7:0]  left_key;
        logic        rhs_immediate;
        logic [7:0]  right_key;
        logic [31:0] operand_value;
    } item_t;

    typedef struct packed {
        logic        key_error;
        logic [31:0] read_data;
        logic        result_flag;
    } result_t;

    typedef struct packed {
        logic        wr_en;
        logic        clear;
        logic [7:0]  key;
        logic [31:0] data;
    } update_t;

endpackage

// File: design/world_state_condition_effect_engine.sv
// Top level of the world-state condition and effect engine.
//
// Each accepted transaction produces exactly one result transaction, and one
// transaction is accepted every cycle as long as the result side keeps up.
// On acceptance the left and right entries are read through the two registered
// read ports of the table RAM; the item register then feeds the checks of keys,
// the compare or update, the write back of the entry and the load of the output
// register. Writes and clears of the item ahead are forwarded, and a valid bit
// per entry makes a clear take effect on every entry together, so back-to-back
// commands on the same entry see each other's results. The entries_in_use
// register may be written over APB only while no transaction is in flight.
module world_state_condition_effect_engine #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], op_code[5:3], left_key[13:6], right_key[21:14],
    // operand_value[53:22], zero[55:54]
    input  logic [55:0] s_tdata,
    // rhs_immediate[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_flag[0], read_data[32:1], key_error[33], zero[39:34]
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [8:0] MAX_LIMIT = 9'(MAX_ENTRIES);

    wsce_pkg::item_t   in_item;
    wsce_pkg::item_t   s1_item_reg;
    logic              s1_valid_reg;
    logic              s1_advance;
    logic              accept;
    logic              out_valid_reg;
    wsce_pkg::result_t out_data_reg;
    logic [6:0]        entries_reg;
    logic [8:0]        limit;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;

    logic              l_ovr_reg;
    logic              l_ovr_next;
    logic [31:0]       l_ovr_data_reg;
    logic [31:0]       l_ovr_data_next;
    logic              r_ovr_reg;
    logic              r_ovr_next;
    logic [31:0]       r_ovr_data_reg;
    logic [31:0]       r_ovr_data_next;

    logic [31:0]       ram_l;
    logic [31:0]       ram_r;
    logic [31:0]       left_value;
    logic [31:0]       right_value;
    wsce_pkg::result_t exec_result;
    wsce_pkg::update_t exec_update;
    logic              commit_wr;
    logic              commit_clr;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     l_addr;
    logic [AW-1:0]     r_addr;

    assign in_item.command       = s_tdata[2:0];
    assign in_item.op_code       = s_tdata[5:3];
    assign in_item.left_key      = s_tdata[13:6];
    assign in_item.right_key     = s_tdata[21:14];
    assign in_item.operand_value = s_tdata[53:22];
    assign in_item.rhs_immediate = s_tuser;

    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;

    assign limit = ({2'b00, entries_reg} < MAX_LIMIT) ? {2'b00, entries_reg} : MAX_LIMIT;

    assign l_addr  = in_item.left_key[AW-1:0];
    assign r_addr  = in_item.right_key[AW-1:0];
    assign wr_addr = exec_update.key[AW-1:0];

    assign commit_wr  = s1_valid_reg && s1_advance && exec_update.wr_en;
    assign commit_clr = s1_valid_reg && s1_advance && exec_update.clear;

    wsce_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (commit_wr),
        .waddr   (wr_addr),
        .wdata   (exec_update.data),
        .re      (accept),
        .raddr_a (l_addr),
        .raddr_b (r_addr),
        .rdata_a (ram_l),
        .rdata_b (ram_r)
    );

    assign left_value  = l_ovr_reg ? l_ovr_data_reg : ram_l;
    assign right_value = r_ovr_reg ? r_ovr_data_reg : ram_r;

    wsce_exec u_exec (
        .item        (s1_item_reg),
        .left_value  (left_value),
        .right_value (right_value),
        .limit       (limit),
        .result      (exec_result),
        .update      (exec_update)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (commit_clr)
        begin
            valid_next = '0;
        end
        else if (commit_wr)
        begin
            valid_next[wr_addr] = 1'b1;
        end

        if (commit_clr)
        begin
            l_ovr_next      = 1'b1;
            l_ovr_data_next = 32'd0;
            r_ovr_next      = 1'b1;
            r_ovr_data_next = 32'd0;
        end
        else
        begin
            if (commit_wr && wr_addr == l_addr)
            begin
                l_ovr_next      = 1'b1;
                l_ovr_data_next = exec_update.data;
            end
            else
            begin
                l_ovr_next      = !valid_reg[l_addr];
                l_ovr_data_next = 32'd0;
            end
            if (commit_wr && wr_addr == r_addr)
            begin
                r_ovr_next      = 1'b1;
                r_ovr_data_next = exec_update.data;
            end
            else
            begin
                r_ovr_next      = !valid_reg[r_addr];
                r_ovr_data_next = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            entries_reg   <= wsce_pkg::ENTRIES_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (psel && penable && pwrite && pready &&
                paddr == wsce_pkg::REG_ENTRIES_IN_USE)
            begin
                entries_reg <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg    <= in_item;
            l_ovr_reg      <= l_ovr_next;
            l_ovr_data_reg <= l_ovr_data_next;
            r_ovr_reg      <= r_ovr_next;
            r_ovr_data_reg <= r_ovr_data_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg.key_error, out_data_reg.read_data,
                       out_data_reg.result_flag};

    assign pready = 1'b1;
    assign prdata = (paddr == wsce_pkg::REG_ENTRIES_IN_USE) ? {25'd0, entries_reg} : 32'd0;

endmodule

// File: design/wsce_ram.sv
// Generic RAM with one write port and two registered read ports.
module wsce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: design/wsce_exec.sv
// Bounds check, comparison and effect arithmetic for one command.
module wsce_exec (
    input  wsce_pkg::item_t   item,
    input  logic [31:0]       left_value,
    input  logic [31:0]       right_value,
    input  logic [8:0]        limit,
    output wsce_pkg::result_t result,
    output wsce_pkg::update_t update
);

    logic        uses_right;
    logic        left_ok;
    logic        right_ok;
    logic        keys_ok;
    logic [31:0] rhs;
    logic        cmp_lt;
    logic        cmp_eq;

    always_comb
    begin
        uses_right = !item.rhs_immediate &&
                     !(item.command == wsce_pkg::CMD_CHECK &&
                       item.op_code == wsce_pkg::OP_NONZERO);
        left_ok    = {1'b0, item.left_key} < limit;
        right_ok   = {1'b0, item.right_key} < limit;
        keys_ok    = left_ok && (!uses_right || right_ok);
        rhs        = uses_right ? right_value : item.operand_value;
        cmp_lt     = $signed(left_value) < $signed(rhs);
        cmp_eq     = left_value == rhs;

        result = '0;
        update = '0;
        update.key = item.left_key;

        case (item.command)
            wsce_pkg::CMD_CHECK:
            begin
                if (item.op_code <= wsce_pkg::OP_NONZERO)
                begin
                    if (!keys_ok)
                    begin
                        result.key_error = 1'b1;
                    end
                    else
                    begin
                        case (item.op_code)
                            wsce_pkg::OP_LT: result.result_flag = cmp_lt;
                            wsce_pkg::OP_LE: result.result_flag = cmp_lt || cmp_eq;
                            wsce_pkg::OP_EQ: result.result_flag = cmp_eq;
                            wsce_pkg::OP_NE: result.result_flag = !cmp_eq;
                            wsce_pkg::OP_GE: result.result_flag = !cmp_lt;
                            wsce_pkg::OP_GT: result.result_flag = !cmp_lt && !cmp_eq;
                            default:         result.result_flag = left_value != 32'd0;
                        endcase
                    end
                end
            end
            wsce_pkg::CMD_EFFECT:
            begin
                if (item.op_code inside {wsce_pkg::OP_SET, wsce_pkg::OP_ADD,
                                         wsce_pkg::OP_SUB})
                begin
                    if (!keys_ok)
                    begin
                        result.key_error = 1'b1;
                    end
                    else
                    begin
                        result.result_flag = 1'b1;
                        update.wr_en = 1'b1;
                        case (item.op_code)
                            wsce_pkg::OP_SET: update.data = rhs;
                            wsce_pkg::OP_ADD: update.data = left_value + rhs;
                            default:          update.data = left_value - rhs;
                        endcase
                    end
                end
            end
            wsce_pkg::CMD_READ:
            begin
                if (left_ok)
                begin
                    result.read_data   = left_value;
                    result.result_flag = 1'b1;
                end
                else
                begin
                    result.key_error = 1'b1;
                end
            end
            wsce_pkg::CMD_WRITE:
            begin
                if (left_ok)
                begin
                    result.result_flag = 1'b1;
                    update.wr_en = 1'b1;
                    update.data  = item.operand_value;
                end
                else
                begin
                    result.key_error = 1'b1;
                end
            end
            wsce_pkg::CMD_CLEAR:
            begin
                result.result_flag = 1'b1;
                update.clear = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// File: design/wsce_checker.sv
// Port-level assertions for the engine and the bind that attaches them.
module wsce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A result that is held back must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A key error never comes with a success flag or read data.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[32:0] == 33'd0)
        else $error("key error result carries data");

    // With the output register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // No result is offered during reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind world_state_condition_effect_engine wsce_checker u_wsce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/wsce_checker.sv
// Transaction checker that predicts and compares the results of the world-state engine.
`timescale 1ns / 100ps

module wsce_scoreboard #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          pending_results,
    output int          fail_count
);

    localparam logic [1:0] ENTRIES_ADDR = 2'(4 * wsce_pkg::REG_ENTRIES_IN_USE);

    logic [31:0]       world_table [MAX_ENTRIES];
    logic [6:0]        entries_setting;
    wsce_pkg::result_t expected_results [$];
    int                mismatches;

    function automatic int key_limit();
        return (entries_setting < MAX_ENTRIES) ? int'(entries_setting) : MAX_ENTRIES;
    endfunction

    function automatic wsce_pkg::result_t evaluate_command(input wsce_pkg::item_t it);
        wsce_pkg::result_t r;
        int                lim;
        logic              op_known;
        logic              uses_right;
        logic [31:0]       lv;
        logic [31:0]       rv;
        r = '0;
        lim = key_limit();
        case (it.command)
            wsce_pkg::CMD_CHECK, wsce_pkg::CMD_EFFECT:
            begin
                op_known = (it.command == wsce_pkg::CMD_CHECK) ?
                           (it.op_code <= wsce_pkg::OP_NONZERO) :
                           (it.op_code <= wsce_pkg::OP_SUB);
                if (op_known)
                begin
                    uses_right = !it.rhs_immediate &&
                                 !(it.command == wsce_pkg::CMD_CHECK &&
                                   it.op_code == wsce_pkg::OP_NONZERO);
                    if (it.left_key >= lim || (uses_right && it.right_key >= lim))
                    begin
                        r.key_error = 1'b1;
                    end
                    else
                    begin
                        lv = world_table[it.left_key];
                        rv = uses_right ? world_table[it.right_key] : it.operand_value;
                        if (it.command == wsce_pkg::CMD_CHECK)
                        begin
                            case (it.op_code)
                                wsce_pkg::OP_LT: r.result_flag = $signed(lv) <  $signed(rv);
                                wsce_pkg::OP_LE: r.result_flag = $signed(lv) <= $signed(rv);
                                wsce_pkg::OP_EQ: r.result_flag = lv == rv;
                                wsce_pkg::OP_NE: r.result_flag = lv != rv;
                                wsce_pkg::OP_GE: r.result_flag = $signed(lv) >= $signed(rv);
                                wsce_pkg::OP_GT: r.result_flag = $signed(lv) >  $signed(rv);
                                default:         r.result_flag = lv != 32'd0;
                            endcase
                        end
                        else
                        begin
                            case (it.op_code)
                                wsce_pkg::OP_SET: world_table[it.left_key] = rv;
                                wsce_pkg::OP_ADD: world_table[it.left_key] = lv + rv;
                                default:          world_table[it.left_key] = lv - rv;
                            endcase
                            r.result_flag = 1'b1;
                        end
                    end
                end
            end
            wsce_pkg::CMD_READ:
            begin
                if (it.left_key < lim)
                begin
                    r.read_data = world_table[it.left_key];
                    r.result_flag = 1'b1;
                end
                else
                begin
                    r.key_error = 1'b1;
                end
            end
            wsce_pkg::CMD_WRITE:
            begin
                if (it.left_key < lim)
                begin
                    world_table[it.left_key] = it.operand_value;
                    r.result_flag = 1'b1;
                end
                else
                begin
                    r.key_error = 1'b1;
                end
            end
            wsce_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    world_table[i] = '0;
                end
                r.result_flag = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp,
                                 input logic [31:0] act);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, exp, act);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wsce_pkg::item_t   it;
        wsce_pkg::result_t exp;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                world_table[i] = '0;
            end
            entries_setting = wsce_pkg::ENTRIES_RESET;
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ENTRIES_ADDR)
            begin
                if (pwrite)
                begin
                    entries_setting = pwdata[6:0];
                end
                else if (prdata !== {25'd0, entries_setting})
                begin
                    note_mismatch("entries_in_use readback", {25'd0, entries_setting}, prdata);
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.command       = s_tdata[2:0];
                it.op_code       = s_tdata[5:3];
                it.left_key      = s_tdata[13:6];
                it.right_key     = s_tdata[21:14];
                it.operand_value = s_tdata[53:22];
                it.rhs_immediate = s_tuser;
                expected_results.push_back(evaluate_command(it));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch("result with no command pending", '0, m_tdata[31:0]);
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (m_tdata[0] !== exp.result_flag)
                        note_mismatch("result_flag", exp.result_flag, m_tdata[0]);
                    if (m_tdata[32:1] !== exp.read_data)
                        note_mismatch("read_data", exp.read_data, m_tdata[32:1]);
                    if (m_tdata[33] !== exp.key_error)
                        note_mismatch("key_error", exp.key_error, m_tdata[33]);
                end
            end
            pending_results <= expected_results.size();
        end
    end

    initial
    begin
        mismatches = 0;
    end

    always @(posedge clk)
    begin
        fail_count <= mismatches;
    end

endmodule

// File: test/tb_world_state_condition_effect_engine.sv
// Top-level testbench that drives commands and register writes into the world-state engine.
`timescale 1ns / 100ps

module tb_world_state_condition_effect_engine;

    localparam int         MAX_ENTRIES  = 64;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         HOLD_CYCLES  = 200;
    localparam logic [1:0] ENTRIES_ADDR = 2'(4 * wsce_pkg::REG_ENTRIES_IN_USE);

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending_results;
    int fail_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int entries_now = wsce_pkg::ENTRIES_RESET;
    int cycle_count = 0;
    bit hold_req = 1'b0;

    world_state_condition_effect_engine #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wsce_scoreboard #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pending_results(pending_results),
        .fail_count     (fail_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_world_state_condition_effect_engine: FAIL");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic wsce_pkg::item_t make_item(input logic [2:0] command,
                                                  input logic [2:0] op_code,
                                                  input logic [7:0] left_key,
                                                  input logic rhs_immediate,
                                                  input logic [7:0] right_key,
                                                  input logic [31:0] operand_value);
        wsce_pkg::item_t it;
        it.command       = command;
        it.op_code       = op_code;
        it.left_key      = left_key;
        it.rhs_immediate = rhs_immediate;
        it.right_key     = right_key;
        it.operand_value = operand_value;
        return it;
    endfunction

    function automatic logic [7:0] pick_key();
        int lim;
        int r;
        lim = (entries_now < MAX_ENTRIES) ? entries_now : MAX_ENTRIES;
        r = $urandom_range(99);
        if (lim > 0 && r < 85)
            return 8'($urandom_range(lim - 1));
        else if (r < 92)
            return 8'(lim);
        else
            return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 32'(int'($urandom_range(8)) - 4);
        else if (r < 50)
        begin
            case ($urandom_range(4))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        else
            return $urandom;
    endfunction

    function automatic wsce_pkg::item_t random_command();
        int          pick;
        logic [2:0]  command;
        logic [2:0]  op_code;
        pick = $urandom_range(99);
        if (pick < 34)
            command = wsce_pkg::CMD_CHECK;
        else if (pick < 58)
            command = wsce_pkg::CMD_EFFECT;
        else if (pick < 72)
            command = wsce_pkg::CMD_READ;
        else if (pick < 90)
            command = wsce_pkg::CMD_WRITE;
        else if (pick < 93)
            command = wsce_pkg::CMD_CLEAR;
        else
            command = 3'($urandom_range(7, 5));
        if (command == wsce_pkg::CMD_CHECK)
            op_code = ($urandom_range(9) != 0) ? 3'($urandom_range(6)) : 3'd7;
        else if (command == wsce_pkg::CMD_EFFECT)
            op_code = ($urandom_range(6) != 0) ? 3'($urandom_range(2)) : 3'($urandom_range(7, 3));
        else
            op_code = 3'($urandom_range(7));
        return make_item(command, op_code, pick_key(), 1'($urandom_range(1)), pick_key(),
                         pick_value());
    endfunction

    task automatic offer_command(input wsce_pkg::item_t it);
        int gap;
        s_tdata  <= {2'b00, it.operand_value, it.right_key, it.left_key, it.op_code, it.command};
        s_tuser  <= it.rhs_immediate;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic apb_set_entries(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRIES_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        entries_now = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int entries, input int count, input int sender_idle,
                             input int receiver_stall, input bit hold_off);
        drain_results();
        apb_set_entries(entries);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        if (hold_off)
            hold_req = 1'b1;
        repeat (count) offer_command(random_command());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_command(make_item(wsce_pkg::CMD_WRITE, wsce_pkg::OP_SET, 8'd0, 1'b1, 8'd0,
                                32'h7fff_ffff));
        offer_command(make_item(wsce_pkg::CMD_WRITE, wsce_pkg::OP_SET, 8'd1, 1'b1, 8'd0,
                                32'h8000_0000));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_LT, 8'd0, 1'b0, 8'd1, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_LE, 8'd1, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_EQ, 8'd0, 1'b1, 8'd0,
                                32'h7fff_ffff));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_NE, 8'd0, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_GE, 8'd1, 1'b1, 8'd0,
                                32'hffff_ffff));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_GT, 8'd0, 1'b0, 8'd1, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_NONZERO, 8'd2, 1'b0, 8'd255,
                                32'd0));
        offer_command(make_item(wsce_pkg::CMD_EFFECT, wsce_pkg::OP_ADD, 8'd0, 1'b1, 8'd0, 32'd1));
        offer_command(make_item(wsce_pkg::CMD_EFFECT, wsce_pkg::OP_SUB, 8'd1, 1'b1, 8'd0, 32'd1));
        offer_command(make_item(wsce_pkg::CMD_EFFECT, wsce_pkg::OP_SET, 8'd63, 1'b1, 8'd0,
                                32'hffff_ffff));
        offer_command(make_item(wsce_pkg::CMD_EFFECT, wsce_pkg::OP_ADD, 8'd2, 1'b0, 8'd63,
                                32'd0));
        offer_command(make_item(wsce_pkg::CMD_READ, wsce_pkg::OP_SET, 8'd0, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_READ, wsce_pkg::OP_SET, 8'd1, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_READ, wsce_pkg::OP_SET, 8'd63, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_READ, wsce_pkg::OP_SET, 8'd64, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_WRITE, wsce_pkg::OP_SET, 8'd255, 1'b1, 8'd0,
                                32'd5));
        offer_command(make_item(wsce_pkg::CMD_CHECK, wsce_pkg::OP_EQ, 8'd0, 1'b0, 8'd200,
                                32'd0));
        offer_command(make_item(wsce_pkg::CMD_EFFECT, 3'd5, 8'd0, 1'b0, 8'd255, 32'd9));
        offer_command(make_item(wsce_pkg::CMD_CHECK, 3'd7, 8'd255, 1'b0, 8'd255, 32'd0));
        offer_command(make_item(3'd6, wsce_pkg::OP_SET, 8'd0, 1'b1, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_CLEAR, wsce_pkg::OP_SET, 8'd0, 1'b0, 8'd0, 32'd0));
        offer_command(make_item(wsce_pkg::CMD_READ, wsce_pkg::OP_SET, 8'd63, 1'b0, 8'd0, 32'd0));

        run_phase(64, 300, 0, 0, 1'b1);
        run_phase(0, 100, 74, 0, 1'b0);
        run_phase(127, 300, 0, 74, 1'b0);
        run_phase(1, 100, 14, 14, 1'b0);
        run_phase(17, 300, 0, 0, 1'b0);
        run_phase(65, 250, 74, 0, 1'b0);
        run_phase(64, 250, 14, 14, 1'b0);

        drain_results();
        repeat (5) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("tb_world_state_condition_effect_engine: PASS");
        end
        else
        begin
            $display("tb_world_state_condition_effect_engine: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
design/wsce_pkg.sv
design/wsce_ram.sv
design/wsce_exec.sv
design/world_state_condition_effect_engine.sv
design/wsce_checker.sv
test/wsce_checker.sv
test/tb_world_state_condition_effect_engine.sv
